// ===== hdl/bdra_pkg.sv =====
package bdra_pkg;

	localparam int WORD_BITS = 32;
	localparam int CNT_W = $clog2(WORD_BITS + 1);
	localparam logic [WORD_BITS-1:0] LIMIT_RESET = WORD_BITS'(1001);

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		word_t numerator_in;
		word_t denominator_in;
	} in_item_t;

	typedef struct packed {
		word_t numerator_out;
		word_t denominator_out;
		logic zero_denominator_error;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV_GO,
		S_DIV_WAIT,
		S_MUL_P,
		S_MUL_Q,
		S_CHECK,
		S_FINISH,
		S_FIT_GO,
		S_FIT_WAIT,
		S_CROSS_A,
		S_CROSS_B,
		S_SELECT,
		S_SEMI_P,
		S_SEMI_Q,
		S_SEMI_END,
		S_DONE
	} state_t;

endpackage

// ===== hdl/bdra_div.sv =====
module bdra_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input bdra_pkg::word_t dividend,
	input bdra_pkg::word_t divisor,
	output logic done,
	output bdra_pkg::word_t quotient,
	output bdra_pkg::word_t remainder
);
	import bdra_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic done_q;
	word_t rem_q;
	word_t quo_q;
	word_t dsr_q;
	logic [WORD_BITS:0] rem_sh;
	logic [WORD_BITS:0] diff;

	// Shift in the next dividend bit and trial-subtract the divisor
	always_comb begin
		rem_sh = {rem_q, quo_q[WORD_BITS-1]};
		diff = rem_sh - {1'b0, dsr_q};
	end

	// Count the steps and flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(WORD_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!diff[WORD_BITS]) begin
				rem_q <= diff[WORD_BITS-1:0];
				quo_q <= {quo_q[WORD_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[WORD_BITS-1:0];
				quo_q <= {quo_q[WORD_BITS-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule

// ===== hdl/bdra_mac.sv =====
module bdra_mac (
	input logic clk,
	input bdra_pkg::word_t addend,
	input bdra_pkg::word_t mul_a,
	input bdra_pkg::word_t mul_b,
	output bdra_pkg::word_t acc
);
	import bdra_pkg::*;

	logic [2*WORD_BITS-1:0] prod;
	word_t acc_q;

	// Multiply and add, keeping the low word as the wrapped result
	always_comb begin
		prod = mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		acc_q <= addend + prod[WORD_BITS-1:0];
	end

	assign acc = acc_q;

endmodule

// ===== hdl/bounded_denominator_rational_approx.sv =====
// Best rational approximation of numerator/denominator with the result's
// denominator bounded by the configured limit (a limit of zero acts as one).
// The fraction is expanded into continued-fraction convergents by a bit-serial
// divider shared with the final semiconvergent step, and all products go
// through one registered multiply-add unit, wrapping to 32 bits. One
// transaction is worked at a time: each continued-fraction term costs one
// bit-serial divide plus the two convergent updates, a fraction may need up
// to about 47 terms, and a result over the limit adds the semiconvergent
// choice. The input is stalled for the whole time; the result waits in an
// output register, and a zero input denominator returns 0/0 with
// zero_denominator_error set.
module bounded_denominator_rational_approx (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input bdra_pkg::word_t cfg_data,
	input logic in_valid,
	output logic in_stall,
	input bdra_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output bdra_pkg::out_item_t out_data
);
	import bdra_pkg::*;

	state_t state_q, state_d;

	word_t limit_q;
	word_t lim_q;
	word_t top_q, bot_q;
	word_t pa_q, pb_q, qa_q, qb_q;
	word_t pc_q, qc_q;
	word_t quot_q, rem_q, rem_prev_q;
	word_t fit_q, x1_q;
	word_t rn_q, rd_q;
	logic err_q;
	logic steps_q;
	logic out_valid_q;
	out_item_t out_q;

	logic div_start;
	word_t div_dividend, div_divisor;
	logic div_done;
	word_t div_quo, div_rem;

	word_t mac_add, mac_a, mac_b, mac_acc;

	word_t least;
	logic stop;
	logic out_free;

	bdra_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.done(div_done),
		.quotient(div_quo),
		.remainder(div_rem)
	);

	bdra_mac u_mac (
		.clk(clk),
		.addend(mac_add),
		.mul_a(mac_a),
		.mul_b(mac_b),
		.acc(mac_acc)
	);

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Stop on a zero remainder, or once the denominator reaches the limit
	assign stop = (rem_q == '0) || (steps_q && (mac_acc >= lim_q));

	// Smallest admissible semiconvergent index (half-a_k test)
	always_comb begin
		if (!quot_q[0] && (x1_q > mac_acc)) begin
			least = {1'b0, quot_q[WORD_BITS-1:1]};
		end else begin
			least = {1'b0, quot_q[WORD_BITS-1:1]} + WORD_BITS'(1);
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and shared-unit operand selection
	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		div_dividend = top_q;
		div_divisor = bot_q;
		mac_add = '0;
		mac_a = '0;
		mac_b = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (in_data.denominator_in == '0) ? S_DONE : S_DIV_GO;
				end
			end
			S_DIV_GO: begin
				div_start = 1'b1;
				state_d = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (div_done) begin
					state_d = S_MUL_P;
				end
			end
			S_MUL_P: begin
				mac_add = pa_q;
				mac_a = pb_q;
				mac_b = quot_q;
				state_d = S_MUL_Q;
			end
			S_MUL_Q: begin
				mac_add = qa_q;
				mac_a = qb_q;
				mac_b = quot_q;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = stop ? S_FINISH : S_DIV_GO;
			end
			S_FINISH: begin
				if (qc_q <= lim_q) begin
					state_d = S_DONE;
				end else if (qb_q != '0) begin
					state_d = S_FIT_GO;
				end else begin
					state_d = S_CROSS_A;
				end
			end
			S_FIT_GO: begin
				div_start = 1'b1;
				div_dividend = lim_q - qa_q;
				div_divisor = qb_q;
				state_d = S_FIT_WAIT;
			end
			S_FIT_WAIT: begin
				if (div_done) begin
					state_d = S_CROSS_A;
				end
			end
			S_CROSS_A: begin
				mac_a = qa_q;
				mac_b = rem_prev_q;
				state_d = S_CROSS_B;
			end
			S_CROSS_B: begin
				mac_a = rem_q;
				mac_b = qb_q;
				state_d = S_SELECT;
			end
			S_SELECT: begin
				state_d = (fit_q < least) ? S_DONE : S_SEMI_P;
			end
			S_SEMI_P: begin
				mac_add = pa_q;
				mac_a = pb_q;
				mac_b = fit_q;
				state_d = S_SEMI_Q;
			end
			S_SEMI_Q: begin
				mac_add = qa_q;
				mac_a = qb_q;
				mac_b = fit_q;
				state_d = S_SEMI_END;
			end
			S_SEMI_END: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// Continued-fraction datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				top_q <= in_data.numerator_in;
				bot_q <= in_data.denominator_in;
				lim_q <= (limit_q == '0) ? WORD_BITS'(1) : limit_q;
				pa_q <= '0;
				pb_q <= WORD_BITS'(1);
				qa_q <= WORD_BITS'(1);
				qb_q <= '0;
				rem_prev_q <= '0;
				steps_q <= 1'b0;
				rn_q <= '0;
				rd_q <= '0;
				err_q <= (in_data.denominator_in == '0);
			end
			S_DIV_WAIT: begin
				quot_q <= div_quo;
				rem_q <= div_rem;
			end
			S_MUL_Q: begin
				pc_q <= mac_acc;
			end
			S_CHECK: begin
				qc_q <= mac_acc;
				if (!stop) begin
					// advance to the next term
					pa_q <= pb_q;
					pb_q <= pc_q;
					qa_q <= qb_q;
					qb_q <= mac_acc;
					top_q <= bot_q;
					bot_q <= rem_q;
					rem_prev_q <= rem_q;
					steps_q <= 1'b1;
				end
			end
			S_FINISH: begin
				rn_q <= pc_q;
				rd_q <= qc_q;
				fit_q <= '0;
			end
			S_FIT_WAIT: begin
				fit_q <= div_quo;
			end
			S_CROSS_B: begin
				x1_q <= mac_acc;
			end
			S_SELECT: begin
				rn_q <= pb_q;
				rd_q <= qb_q;
			end
			S_SEMI_Q: begin
				rn_q <= mac_acc;
			end
			S_SEMI_END: begin
				rd_q <= mac_acc;
			end
			default: begin
				x1_q <= x1_q;
			end
		endcase
	end

	// Output register: load when free, drop once the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_q.numerator_out <= rn_q;
			out_q.denominator_out <= rd_q;
			out_q.zero_denominator_error <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
